// ----- hdl/stis_pkg.sv -----
// Package for the square-wave tone I2S serializer: field widths, command codes,
// saturation limits, the start calculator's state type and its status struct.
// Depends on nothing; every other file of the block but stis_slot_if uses it.
package stis_pkg;

  // Field widths of the command and slot items.
  localparam int unsigned FREQ_W   = 16;
  localparam int unsigned MS_W     = 16;
  localparam int unsigned AMP_W    = 15;
  localparam int unsigned SAMPLE_W = 16;

  // Tone state widths.
  localparam int unsigned HALF_W  = 12;
  localparam int unsigned COUNT_W = 20;
  localparam int unsigned SLOT_W  = 5;

  // Divisor register width: twice a 16-bit frequency.
  localparam int unsigned DVS_W = FREQ_W + 1;

  // Configuration port.
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_AMPLITUDE = 1'b0;

  // Command codes.
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_TICK  = 1'b1;

  // Defaults and limits.
  localparam int unsigned        SAMPLE_RATE_DEFAULT = 8000;
  localparam int unsigned        MS_PER_S            = 1000;
  localparam logic [AMP_W-1:0]   AMP_RESET           = 15'h2000;
  localparam logic [HALF_W-1:0]  HALF_MAX            = 12'hFFF;
  localparam logic [COUNT_W-1:0] SAMPLES_MAX         = 20'hFFFFF;
  localparam logic [SLOT_W-1:0]  SLOT_LAST           = 5'd31;

  typedef enum logic [2:0] {
    CALC_IDLE,
    CALC_DIV_HALF,
    CALC_SETUP_COUNT,
    CALC_DIV_COUNT,
    CALC_LOAD
  } stis_calc_state_t;

  // Status of the start calculator as seen by the top level.
  typedef struct packed {
    logic               busy;
    logic               load;
    logic [HALF_W-1:0]  half;
    logic [COUNT_W-1:0] count;
  } stis_calc_stat_t;

endpackage

// ----- hdl/stis_cmd_if.sv -----
// Command channel of the tone serializer: valid/ready handshake carrying one
// start or tick item. Depends on stis_pkg for the field widths.
interface stis_cmd_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [stis_pkg::FREQ_W-1:0] tone_freq;
  logic [stis_pkg::MS_W-1:0]   tone_ms;

  modport source (output valid, output cmd, output tone_freq, output tone_ms, input ready);
  modport sink   (input valid, input cmd, input tone_freq, input tone_ms, output ready);
endinterface

// ----- hdl/stis_slot_if.sv -----
// Slot channel of the tone serializer: valid/ready handshake carrying one
// I2S bit slot item. Depends on stis_pkg only through the users of the channel.
interface stis_slot_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic word_select;
  logic playing;
  logic tone_done;

  modport source (output valid, output data_bit, output word_select, output playing,
                  output tone_done, input ready);
  modport sink   (input valid, input data_bit, input word_select, input playing,
                  input tone_done, output ready);
endinterface

// ----- hdl/stis_start_calc.sv -----
// Start calculator: bit-serial restoring divider and shift-add multiplier that
// derive the half period and the sample count of a tone. Depends on stis_pkg.
module stis_start_calc #(
  parameter int unsigned SAMPLE_RATE_HZ = stis_pkg::SAMPLE_RATE_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             go,
  input  logic [stis_pkg::FREQ_W-1:0]      freq,
  input  logic [stis_pkg::MS_W-1:0]        ms,
  output stis_pkg::stis_calc_stat_t        stat
);

  localparam int unsigned RATE_W = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int unsigned PROD_W = RATE_W + stis_pkg::MS_W;
  localparam int unsigned STEP_W = $clog2(PROD_W);
  localparam int unsigned DVS_W  = stis_pkg::DVS_W;
  localparam logic [PROD_W-1:0] RATE_EXT   = PROD_W'(SAMPLE_RATE_HZ);
  localparam logic [DVS_W-1:0]  MS_DIVISOR = DVS_W'(stis_pkg::MS_PER_S);
  localparam logic [STEP_W-1:0] LAST_STEP  = STEP_W'(PROD_W - 1);

  stis_pkg::stis_calc_state_t state, state_next;

  logic [STEP_W-1:0]           step;
  logic [DVS_W-1:0]            rem;
  logic [PROD_W-1:0]           quo;
  logic [DVS_W-1:0]            dvs;
  logic [PROD_W-1:0]           acc;
  logic [PROD_W-1:0]           mcand;
  logic [stis_pkg::MS_W-1:0]   mplier;
  logic [stis_pkg::HALF_W-1:0] half;

  logic [DVS_W:0]   rem_sh;
  logic [DVS_W+1:0] diff;
  logic             ge;

  // One restoring division step: bring down the next dividend bit.
  assign rem_sh = {rem, quo[PROD_W-1]};
  assign diff   = {1'b0, rem_sh} - {2'b00, dvs};
  assign ge     = ~diff[DVS_W+1];

  always_comb begin
    state_next = state;
    case (state)
      stis_pkg::CALC_IDLE: begin
        if (go) state_next = stis_pkg::CALC_DIV_HALF;
      end
      stis_pkg::CALC_DIV_HALF: begin
        if (step == LAST_STEP) state_next = stis_pkg::CALC_SETUP_COUNT;
      end
      stis_pkg::CALC_SETUP_COUNT: begin
        // A zero half period rejects the start without touching the tone.
        if (quo == '0) state_next = stis_pkg::CALC_IDLE;
        else state_next = stis_pkg::CALC_DIV_COUNT;
      end
      stis_pkg::CALC_DIV_COUNT: begin
        if (step == LAST_STEP) state_next = stis_pkg::CALC_LOAD;
      end
      stis_pkg::CALC_LOAD: begin
        state_next = stis_pkg::CALC_IDLE;
      end
      default: state_next = stis_pkg::CALC_IDLE;
    endcase
  end

  always_comb begin
    stat.busy  = 1'b1;
    stat.load  = 1'b0;
    stat.half  = half;
    stat.count = (|quo[PROD_W-1:stis_pkg::COUNT_W]) ? stis_pkg::SAMPLES_MAX
                                                    : quo[stis_pkg::COUNT_W-1:0];
    case (state)
      stis_pkg::CALC_IDLE: stat.busy = 1'b0;
      stis_pkg::CALC_LOAD: stat.load = 1'b1;
      default: stat.busy = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= stis_pkg::CALC_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      stis_pkg::CALC_IDLE: begin
        if (go) begin
          quo    <= RATE_EXT;
          rem    <= '0;
          dvs    <= {freq, 1'b0};
          mcand  <= RATE_EXT;
          mplier <= ms;
          acc    <= '0;
          step   <= '0;
        end
      end
      stis_pkg::CALC_DIV_HALF: begin
        // The rate-times-duration product is built alongside the first division.
        rem    <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo    <= {quo[PROD_W-2:0], ge};
        step   <= step + 1'b1;
        if (mplier[0]) acc <= acc + mcand;
        mcand  <= {mcand[PROD_W-2:0], 1'b0};
        mplier <= {1'b0, mplier[stis_pkg::MS_W-1:1]};
      end
      stis_pkg::CALC_SETUP_COUNT: begin
        half <= (|quo[PROD_W-1:stis_pkg::HALF_W]) ? stis_pkg::HALF_MAX
                                                 : quo[stis_pkg::HALF_W-1:0];
        quo  <= acc;
        rem  <= '0;
        dvs  <= MS_DIVISOR;
        step <= '0;
      end
      stis_pkg::CALC_DIV_COUNT: begin
        rem  <= ge ? diff[DVS_W-1:0] : rem_sh[DVS_W-1:0];
        quo  <= {quo[PROD_W-2:0], ge};
        step <= step + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- hdl/square_tone_i2s_serializer_unit.sv -----
// Top level of the square-wave tone I2S serializer: command and slot channels,
// APB amplitude register and the bit-slot sequencer. Depends on stis_pkg,
// stis_cmd_if, stis_slot_if and stis_start_calc.
//
// The block plays a square-wave tone as 16-bit stereo I2S, one bit slot per
// tick item on the command channel, and returns one slot item per tick with
// the data bit, word select, a playing flag and a flag on the tone's final
// slot. A tick is accepted whenever the start calculator is idle and the slot
// output register is empty or being emptied, so ticks may arrive on consecutive
// cycles. A start item with a non-zero frequency and duration launches the start
// calculator, a shared bit-serial restoring divider with a shift-add multiplier
// running beside it: it divides the sample rate by twice the frequency, then
// the rate-times-duration product by 1000, one quotient bit per cycle. The
// command channel then stays closed while those two divisions run; when the
// first division gives a zero half period the start is dropped after it. A start
// with a zero frequency or duration is absorbed without launching the calculator.
// The new tone replaces any tone that was playing. Samples go out MSB first
// from a 15-bit shift register that is reloaded at the first slot of each
// channel word. The amplitude register is to be written through the APB port
// only while no item is in progress; the block itself does not enforce this.
module square_tone_i2s_serializer_unit #(
  parameter int unsigned SAMPLE_RATE_HZ = stis_pkg::SAMPLE_RATE_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  stis_cmd_if.sink                            command,
  stis_slot_if.source                         slot,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [stis_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [stis_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [stis_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready
);

  // Configuration and tone state.
  logic [stis_pkg::AMP_W-1:0]   amplitude;
  logic                         active;
  logic [stis_pkg::COUNT_W-1:0] samples_left;
  logic [stis_pkg::HALF_W-1:0]  half_period_len;
  logic [stis_pkg::HALF_W-1:0]  phase_count;
  logic                         level_high;
  logic [stis_pkg::SLOT_W-1:0]  bit_slot;
  logic                         ws_level;
  logic [stis_pkg::AMP_W-1:0]   word_sr;

  // Slot output register.
  logic out_valid;
  logic out_data;
  logic out_ws;
  logic out_playing;
  logic out_done;

  stis_pkg::stis_calc_stat_t calc_stat;

  logic                          tick_acc;
  logic                          start_acc;
  logic                          go;
  logic                          cfg_write;
  logic [stis_pkg::SAMPLE_W-1:0] sample;
  logic                          slot_last;
  logic                          word_first;
  logic                          word_last;
  logic                          data_now;
  logic                          ws_now;
  logic [stis_pkg::HALF_W-1:0]   phase_inc;
  logic                          phase_wrap;
  logic                          last_sample;

  // The command channel opens only when the calculator is idle and the slot
  // register can take a new item.
  assign command.ready = ~calc_stat.busy & (~out_valid | slot.ready);
  assign tick_acc  = command.valid & command.ready & (command.cmd == stis_pkg::CMD_TICK);
  assign start_acc = command.valid & command.ready & (command.cmd == stis_pkg::CMD_START);
  assign go        = start_acc & (command.tone_freq != '0) & (command.tone_ms != '0);

  assign cfg_write = psel & penable & pwrite & pready;
  assign pready    = 1'b1;
  assign prdata    = (paddr[2] == stis_pkg::REG_AMPLITUDE)
                     ? stis_pkg::APB_DATA_W'(amplitude) : '0;

  stis_start_calc #(
    .SAMPLE_RATE_HZ(SAMPLE_RATE_HZ)
  ) u_calc (
    .clk (clk),
    .rst (rst),
    .go  (go),
    .freq(command.tone_freq),
    .ms  (command.tone_ms),
    .stat(calc_stat)
  );

  // Sample is the amplitude or its two's complement negation in 16 bits.
  assign sample = level_high ? {1'b0, amplitude} : (~{1'b0, amplitude} + 16'd1);

  assign slot_last   = (bit_slot == stis_pkg::SLOT_LAST);
  assign word_first  = (bit_slot[3:0] == 4'h0);
  assign word_last   = (bit_slot[3:0] == 4'hF);
  assign data_now    = word_first ? sample[stis_pkg::SAMPLE_W-1] : word_sr[stis_pkg::AMP_W-1];
  // Word select moves to the channel number on the last bit of each word.
  assign ws_now      = word_last ? bit_slot[4] : ws_level;
  assign phase_inc   = phase_count + 1'b1;
  assign phase_wrap  = (phase_inc >= half_period_len);
  assign last_sample = (samples_left == stis_pkg::COUNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude       <= stis_pkg::AMP_RESET;
      active          <= 1'b0;
      samples_left    <= '0;
      half_period_len <= '0;
      phase_count     <= '0;
      level_high      <= 1'b1;
      bit_slot        <= '0;
      ws_level        <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write && (paddr[2] == stis_pkg::REG_AMPLITUDE)) begin
        amplitude <= pwdata[stis_pkg::AMP_W-1:0];
      end

      if (tick_acc) begin
        out_valid <= 1'b1;
      end else if (slot.ready) begin
        out_valid <= 1'b0;
      end

      if (calc_stat.load) begin
        // A start restarts the tone from the top of a high half period.
        half_period_len <= calc_stat.half;
        samples_left    <= calc_stat.count;
        phase_count     <= '0;
        level_high      <= 1'b1;
        bit_slot        <= '0;
        active          <= (calc_stat.count != '0);
      end else if (tick_acc && active) begin
        ws_level <= ws_now;
        if (slot_last) begin
          // End of a stereo sample: step the phase and the sample count.
          bit_slot     <= '0;
          samples_left <= samples_left - 1'b1;
          phase_count  <= phase_wrap ? '0 : phase_inc;
          if (phase_wrap) level_high <= ~level_high;
          if (last_sample) active <= 1'b0;
        end else begin
          bit_slot <= bit_slot + 1'b1;
        end
      end
    end
  end

  // Payload and data shift register carry no reset.
  always_ff @(posedge clk) begin
    if (tick_acc) begin
      out_data    <= active & data_now;
      out_ws      <= active ? ws_now : ws_level;
      out_playing <= active;
      out_done    <= active & slot_last & last_sample;
      if (active) begin
        word_sr <= word_first ? sample[stis_pkg::AMP_W-1:0]
                              : {word_sr[stis_pkg::AMP_W-2:0], 1'b0};
      end
    end
  end

  assign slot.valid       = out_valid;
  assign slot.data_bit    = out_data;
  assign slot.word_select = out_ws;
  assign slot.playing     = out_playing;
  assign slot.tone_done   = out_done;

  // A playing tone always has at least one sample still to send.
  a_active_has_samples: assert property (@(posedge clk) disable iff (rst)
    active |-> (samples_left != '0))
    else $error("active tone with no samples left");

  // The phase counter stays below the half period while a tone plays.
  a_phase_in_range: assert property (@(posedge clk) disable iff (rst)
    active |-> (phase_count < half_period_len))
    else $error("phase counter reached the half period");

  // Between tones the slot counter rests at the first slot.
  a_idle_slot_zero: assert property (@(posedge clk) disable iff (rst)
    !active |-> (bit_slot == '0))
    else $error("slot counter moved while idle");

  // A held final slot means the tone has ended and nothing has restarted it.
  a_done_ends_tone: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_done) |-> !active)
    else $error("tone still active after its final slot");

  // The calculator only finishes when the command channel is closed.
  a_load_blocks_items: assert property (@(posedge clk) disable iff (rst)
    calc_stat.load |-> !(tick_acc || start_acc))
    else $error("item accepted while a start was being loaded");

endmodule

// ----- tb/sv/tb_square_tone_i2s_serializer_unit.sv -----
// Self-checking testbench for the square-wave tone I2S serializer.
// It drives the command channel and the APB port, predicts every slot item
// and compares it. Needs stis_pkg, stis_cmd_if, stis_slot_if and the RTL.
module tb_square_tone_i2s_serializer_unit;
  timeunit 1ns;
  timeprecision 1ps;

  // The block runs at its default sample rate. One millisecond of tone is
  // RATE/1000 samples, and each sample is 32 bit slots.
  localparam int unsigned RATE          = stis_pkg::SAMPLE_RATE_DEFAULT;
  localparam int unsigned SLOTS_PER_MS  = RATE / stis_pkg::MS_PER_S * 32;
  // A start keeps the command channel closed while the divider runs, and a
  // start yields no slot item, so before a register write the testbench lets
  // the divider finish with some margin.
  localparam int unsigned CALC_SETTLE   = 100;
  localparam int unsigned END_SETTLE    = 20;
  localparam int unsigned LONG_HOLD     = 200;
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned ITEM_TARGET   = 1900;
  localparam logic [stis_pkg::APB_ADDR_W-1:0] AMP_ADDR =
    stis_pkg::APB_ADDR_W'(4 * int'(stis_pkg::REG_AMPLITUDE));

  typedef struct packed {
    logic data_bit;
    logic word_select;
    logic playing;
    logic tone_done;
  } slot_item_t;

  logic                            clk;
  logic                            rst;
  logic                            psel;
  logic                            penable;
  logic                            pwrite;
  logic [stis_pkg::APB_ADDR_W-1:0] paddr;
  logic [stis_pkg::APB_DATA_W-1:0] pwdata;
  logic [stis_pkg::APB_DATA_W-1:0] prdata;
  logic                            pready;

  stis_cmd_if  cmd_ch ();
  stis_slot_if slot_ch ();

  square_tone_i2s_serializer_unit #(
    .SAMPLE_RATE_HZ(RATE)
  ) DUT (
    .clk     (clk),
    .rst     (rst),
    .command (cmd_ch),
    .slot    (slot_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Our own copy of the tone generator: amplitude register, tone state and
  // the serializer position within the current sample.
  logic [stis_pkg::AMP_W-1:0]   amp_reg;
  logic                         tone_on;
  logic [stis_pkg::COUNT_W-1:0] samples_left;
  logic [stis_pkg::HALF_W-1:0]  half_len;
  logic [stis_pkg::HALF_W-1:0]  phase_cnt;
  logic                         level_hi;
  logic [stis_pkg::SLOT_W-1:0]  slot_idx;
  logic                         ws_lvl;

  // Slot items predicted for accepted ticks, oldest first.
  slot_item_t expected_slots[$];

  int unsigned errors;
  int unsigned items_sent;
  int unsigned starts_sent;
  int unsigned ticks_sent;
  int unsigned slots_checked;
  int unsigned tones_finished;

  // Switches for the idling of either side; the long hold-off is requested
  // by a test and carried out by the receiver's own process.
  bit src_gaps_on;
  bit sink_stalls_on;
  bit long_hold_req;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // A start loads a new tone unless the frequency or the duration is zero or
  // the half period truncates to zero. Both values saturate at their widths.
  function automatic void load_tone(logic [stis_pkg::FREQ_W-1:0] freq,
                                    logic [stis_pkg::MS_W-1:0] ms);
    longint unsigned half_q;
    longint unsigned count_q;
    if (freq == '0 || ms == '0) return;
    half_q = longint'(RATE) / (2 * longint'(freq));
    if (half_q == 0) return;
    if (half_q > stis_pkg::HALF_MAX) half_q = stis_pkg::HALF_MAX;
    count_q = longint'(RATE) * longint'(ms) / stis_pkg::MS_PER_S;
    if (count_q > stis_pkg::SAMPLES_MAX) count_q = stis_pkg::SAMPLES_MAX;
    half_len     = stis_pkg::HALF_W'(half_q);
    samples_left = stis_pkg::COUNT_W'(count_q);
    phase_cnt    = '0;
    level_hi     = 1'b1;
    slot_idx     = '0;
    tone_on      = (count_q != 0);
  endfunction

  // One tick: the slot item it yields, and the advance of the serializer.
  function automatic slot_item_t next_slot();
    slot_item_t                    r;
    logic [stis_pkg::SAMPLE_W-1:0] smp;
    logic [3:0]                    bitn;
    r = '0;
    if (!tone_on) begin
      // An idle tick only repeats the held word-select level.
      r.word_select = ws_lvl;
      return r;
    end
    bitn = slot_idx[3:0];
    smp  = level_hi ? {1'b0, amp_reg} : stis_pkg::SAMPLE_W'(0) - {1'b0, amp_reg};
    r.data_bit = smp[4'd15 - bitn];
    // Word select changes one slot ahead of the next word, as I2S requires.
    if (bitn == 4'd15) ws_lvl = slot_idx[4];
    r.word_select = ws_lvl;
    r.playing     = 1'b1;
    if (slot_idx == stis_pkg::SLOT_LAST) begin
      slot_idx = '0;
      if (samples_left != '0) samples_left--;
      phase_cnt++;
      if (phase_cnt >= half_len) begin
        phase_cnt = '0;
        level_hi  = !level_hi;
      end
      if (samples_left == '0) begin
        tone_on     = 1'b0;
        r.tone_done = 1'b1;
      end
    end else begin
      slot_idx++;
    end
    return r;
  endfunction

  // Offers one item on the command channel and updates the prediction once
  // it is taken. valid stays high afterwards so that the next item may follow
  // on the very next cycle; it is only lowered where a gap is wanted.
  task automatic send_item(input logic cmd, input logic [stis_pkg::FREQ_W-1:0] freq,
                           input logic [stis_pkg::MS_W-1:0] ms);
    int unsigned gap;
    gap = src_gaps_on ? pick_gap() : 0;
    if (gap != 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid     <= 1'b1;
    cmd_ch.cmd       <= cmd;
    cmd_ch.tone_freq <= freq;
    cmd_ch.tone_ms   <= ms;
    do @(posedge clk); while (!cmd_ch.ready);
    items_sent++;
    if (cmd == stis_pkg::CMD_START) begin
      starts_sent++;
      load_tone(freq, ms);
    end else begin
      ticks_sent++;
      expected_slots.push_back(next_slot());
    end
  endtask

  // Ticks carry random frequency and duration fields, which must be ignored.
  task automatic send_ticks(input int unsigned n);
    repeat (n) send_item(stis_pkg::CMD_TICK, stis_pkg::FREQ_W'($urandom()),
                         stis_pkg::MS_W'($urandom()));
  endtask

  // The sender pauses until every predicted slot item has come back.
  task automatic wait_results_done();
    cmd_ch.valid <= 1'b0;
    do @(posedge clk); while (expected_slots.size() != 0);
  endtask

  // Brings the block to rest before a register write: the running tone is
  // played out, the results are drained and the divider is given time.
  task automatic settle_block();
    while (tone_on) send_ticks(1);
    wait_results_done();
    repeat (CALC_SETTLE) @(posedge clk);
  endtask

  // One APB transfer: setup cycle, then access until pready is seen.
  task automatic reg_access(input bit wr, input logic [stis_pkg::APB_DATA_W-1:0] wdata,
                            output logic [stis_pkg::APB_DATA_W-1:0] rdata);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= AMP_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    rdata = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Writes the amplitude, keeps the low 15 bits as the register does, leaves
  // the bus idle and then reads the register back.
  task automatic set_amplitude(input logic [stis_pkg::APB_DATA_W-1:0] value);
    logic [stis_pkg::APB_DATA_W-1:0] rd;
    reg_access(1'b1, value, rd);
    amp_reg = value[stis_pkg::AMP_W-1:0];
    @(posedge clk);
    reg_access(1'b0, '0, rd);
    if (rd !== stis_pkg::APB_DATA_W'(amp_reg)) begin
      $error("amplitude: expected %0h, got %0h", amp_reg, rd);
      errors++;
    end
  endtask

  task automatic test_register_reset();
    logic [stis_pkg::APB_DATA_W-1:0] rd;
    reg_access(1'b0, '0, rd);
    if (rd !== stis_pkg::APB_DATA_W'(stis_pkg::AMP_RESET)) begin
      $error("amplitude: expected %0h, got %0h", stis_pkg::AMP_RESET, rd);
      errors++;
    end
  endtask

  // Idle ticks around starts that must all be refused: zero frequency, zero
  // duration, and frequencies so high that the half period truncates to zero.
  task automatic test_rejected_starts();
    send_item(stis_pkg::CMD_TICK, 16'hFFFF, 16'hFFFF);
    send_item(stis_pkg::CMD_START, 16'd0, 16'd100);
    send_item(stis_pkg::CMD_START, 16'd440, 16'd0);
    send_item(stis_pkg::CMD_START, 16'hFFFF, 16'hFFFF);
    send_item(stis_pkg::CMD_START, 16'd4001, 16'd1);
    send_item(stis_pkg::CMD_TICK, 16'd0, 16'd0);
    send_item(stis_pkg::CMD_TICK, 16'h5555, 16'hAAAA);
  endtask

  // The lowest frequency with the longest duration, cut short mid-word by a
  // restart at the highest frequency that still gives a one-sample half period.
  task automatic test_field_extremes();
    send_item(stis_pkg::CMD_START, 16'd1, 16'hFFFF);
    send_ticks(5);
    send_item(stis_pkg::CMD_START, 16'd4000, 16'd1);
    send_ticks(8);
  endtask

  // One complete one-millisecond tone per amplitude setting, including both
  // extremes and a write whose upper bits must be dropped, then a couple of
  // idle ticks that show the held word select.
  task automatic test_amplitude_settings();
    logic [stis_pkg::APB_DATA_W-1:0] amps[4];
    logic [stis_pkg::FREQ_W-1:0]     freqs[4];
    amps[0]  = '0;
    amps[1]  = '1;
    amps[2]  = 32'h0000_2AAA;
    amps[3]  = $urandom();
    freqs[0] = 16'd4000;
    freqs[1] = 16'd2000;
    freqs[2] = 16'd1000;
    freqs[3] = stis_pkg::FREQ_W'($urandom_range(1000, 4000));
    for (int i = 0; i < 4; i++) begin
      settle_block();
      set_amplitude(amps[i]);
      send_item(stis_pkg::CMD_START, freqs[i], 16'd1);
      send_ticks(SLOTS_PER_MS + 2);
    end
  endtask

  // The receiver holds off for a long stretch while ticks are offered back to
  // back, so the slot register fills and the command channel must close.
  // Afterwards the sender waits for every outstanding result.
  task automatic test_output_backpressure();
    send_item(stis_pkg::CMD_START, 16'd2000, 16'd1);
    src_gaps_on    = 1'b0;
    sink_stalls_on = 1'b0;
    long_hold_req  = 1'b1;
    send_ticks(40);
    src_gaps_on    = 1'b1;
    sink_stalls_on = 1'b1;
    wait_results_done();
    send_ticks(24);
  endtask

  // Random sequences until the item budget is spent. Most are well-formed
  // tones played to their end; the rest are tones cut short by a restart and
  // noisy starts with arbitrary fields, many of them refused.
  task automatic test_random_tones();
    int unsigned                 kind;
    int unsigned                 nticks;
    logic [stis_pkg::FREQ_W-1:0] freq;
    logic [stis_pkg::MS_W-1:0]   ms;
    while (items_sent < ITEM_TARGET) begin
      src_gaps_on    = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
        freq   = stis_pkg::FREQ_W'($urandom_range(500, 4000));
        ms     = 16'd1;
        nticks = SLOTS_PER_MS + $urandom_range(0, 6);
      end else if (kind < 85) begin
        freq   = stis_pkg::FREQ_W'($urandom_range(1, 4000));
        ms     = stis_pkg::MS_W'($urandom_range(1, 65535));
        nticks = $urandom_range(0, 200);
      end else begin
        freq   = stis_pkg::FREQ_W'($urandom());
        ms     = stis_pkg::MS_W'($urandom());
        nticks = $urandom_range(0, 40);
      end
      send_item(stis_pkg::CMD_START, freq, ms);
      send_ticks(nticks);
    end
  endtask

  // Receiver: ready with random stalls, or the long hold-off on request. The
  // hold-off is counted here, in cycles, independent of the sender.
  initial begin : slot_receiver
    int unsigned hold;
    hold          = 0;
    slot_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold != 0) begin
        hold--;
        slot_ch.ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        hold          = LONG_HOLD - 1;
        slot_ch.ready <= 1'b0;
      end else if (sink_stalls_on && $urandom_range(0, 99) < 12) begin
        hold          = pick_gap();
        slot_ch.ready <= 1'b0;
      end else begin
        slot_ch.ready <= 1'b1;
      end
    end
  end

  // Every accepted slot item is compared field by field with the oldest
  // prediction. Values are read at the clock edge, before any update lands.
  always @(posedge clk) begin : slot_checker
    slot_item_t want;
    if (!rst && slot_ch.valid && slot_ch.ready) begin
      if (expected_slots.size() == 0) begin
        $error("slot item arrived with no tick outstanding");
        errors++;
      end else begin
        want = expected_slots.pop_front();
        slots_checked++;
        if (want.tone_done) tones_finished++;
        if (slot_ch.data_bit !== want.data_bit) begin
          $error("data_bit: expected %0b, got %0b", want.data_bit, slot_ch.data_bit);
          errors++;
        end
        if (slot_ch.word_select !== want.word_select) begin
          $error("word_select: expected %0b, got %0b", want.word_select,
                 slot_ch.word_select);
          errors++;
        end
        if (slot_ch.playing !== want.playing) begin
          $error("playing: expected %0b, got %0b", want.playing, slot_ch.playing);
          errors++;
        end
        if (slot_ch.tone_done !== want.tone_done) begin
          $error("tone_done: expected %0b, got %0b", want.tone_done, slot_ch.tone_done);
          errors++;
        end
      end
    end
  end

  // The run is abandoned if nothing moves on any port for too long. The limit
  // covers the long hold-off, the divider and the settling before writes.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk);
      if ((cmd_ch.valid && cmd_ch.ready) || (slot_ch.valid && slot_ch.ready) ||
          (psel && penable))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no progress for %0d cycles, %0d slot items outstanding.",
             quiet, expected_slots.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : run_tests
    rst              = 1'b1;
    cmd_ch.valid     = 1'b0;
    cmd_ch.cmd       = stis_pkg::CMD_TICK;
    cmd_ch.tone_freq = '0;
    cmd_ch.tone_ms   = '0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = AMP_ADDR;
    pwdata           = '0;
    errors           = 0;
    items_sent       = 0;
    starts_sent      = 0;
    ticks_sent       = 0;
    slots_checked    = 0;
    tones_finished   = 0;
    src_gaps_on      = 1'b1;
    sink_stalls_on   = 1'b1;
    long_hold_req    = 1'b0;
    // Predicted state after reset.
    amp_reg      = stis_pkg::AMP_RESET;
    tone_on      = 1'b0;
    samples_left = '0;
    half_len     = '0;
    phase_cnt    = '0;
    level_hi     = 1'b1;
    slot_idx     = '0;
    ws_lvl       = 1'b0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_register_reset();
    test_rejected_starts();
    test_field_extremes();
    test_amplitude_settings();
    test_output_backpressure();
    test_random_tones();

    wait_results_done();
    repeat (END_SETTLE) @(posedge clk);
    if (expected_slots.size() != 0) begin
      $error("%0d slot items never arrived", expected_slots.size());
      errors++;
    end

    $display("Covered %0d starts and %0d ticks, %0d slot items compared.",
             starts_sent, ticks_sent, slots_checked);
    $display("%0d tones ran to their last slot; amplitude tried at zero, full scale and more.",
             tones_finished);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
